/* rtl/queue_from_two_stacks_core_defines.svh */
// assertion macros for the two-stack queue
`ifndef QUEUE_FROM_TWO_STACKS_CORE_DEFINES_SVH
`define QUEUE_FROM_TWO_STACKS_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qts assertion failed");

// next-cycle implication, checked outside reset
`define QTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qts assertion failed");

`endif

/* rtl/qts_pkg.sv */
package qts_pkg;

	// default sizes
	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	// fixed field widths
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	// control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MOVE,
		ST_POP_RD,
		ST_RESP
	} state_t;

endpackage

/* rtl/qts_stack_mem.sv */
module qts_stack_mem #(
	parameter int DEPTH  = qts_pkg::DEPTH_DEF,
	parameter int DATA_W = qts_pkg::DATA_W_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/queue_from_two_stacks_core.sv */
// channel   | handshake              | payload
// ----------+------------------------+------------------------------
// input     | in_valid / in_stall    | command, value
// result    | out_valid / out_stall  | out_value, status
// config    | cfg_write              | cfg_data (capacity)
//
// enqueue, overflow and underflow pass through EXEC and RESP; a plain pop
// adds POP_RD for the pop memory read; a pop that refills the pop stack
// stays in MOVE, moving one entry per cycle through the push memory read
// port until the push stack is empty. No clearing pass after reset; counts reset to zero.
// The next item is taken in the cycle its predecessor's result enters the
// output register, which holds a stalled result while work goes on.
module queue_from_two_stacks_core #(
	parameter int DEPTH      = qts_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = qts_pkg::DATA_W_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [qts_pkg::CAP_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic signed [qts_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [qts_pkg::VAL_W-1:0] out_value,
	output logic [1:0]                      status
);

	import qts_pkg::*;

`include "queue_from_two_stacks_core_defines.svh"

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    push_cnt_q, pop_cnt_q;
	logic [AW-1:0]    mv_rd_q;
	logic             cmd_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] res_val_q;
	status_t          res_stat_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_val_q;
	status_t          out_stat_q;

	logic              push_we, push_re, pop_we, pop_re;
	logic [AW-1:0]     push_raddr, pop_raddr, pop_waddr, push_top, pop_top;
	logic [DATA_WIDTH-1:0] push_wdata, push_rdata, pop_rdata;
	logic [VAL_W-1:0]  push_rd_ext, pop_rd_ext;

	logic in_xfer, out_free, out_load, overflow, move_last;

	// width conversion between the port values and the stored words
	generate
		if (DATA_WIDTH > VAL_W) begin : g_wide
			assign push_wdata  = {{(DATA_WIDTH-VAL_W){1'b0}}, val_q};
			assign push_rd_ext = push_rdata[VAL_W-1:0];
			assign pop_rd_ext  = pop_rdata[VAL_W-1:0];
		end else if (DATA_WIDTH == VAL_W) begin : g_same
			assign push_wdata  = val_q;
			assign push_rd_ext = push_rdata;
			assign pop_rd_ext  = pop_rdata;
		end else begin : g_narrow
			assign push_wdata  = val_q[DATA_WIDTH-1:0];
			assign push_rd_ext = {{(VAL_W-DATA_WIDTH){1'b0}}, push_rdata};
			assign pop_rd_ext  = {{(VAL_W-DATA_WIDTH){1'b0}}, pop_rdata};
		end
	endgenerate

	// handshake and status helpers
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_RESP) && out_free;
	assign in_stall  = !((state_q == ST_IDLE) || out_load);
	assign in_xfer   = in_valid && !in_stall;
	assign overflow  = (CMPW'(push_cnt_q) >= CMPW'(cap_q)) || (push_cnt_q == CW'(DEPTH));
	assign push_top  = AW'(push_cnt_q - 1'b1);
	assign pop_top   = AW'(pop_cnt_q - 1'b1);
	assign move_last = (mv_rd_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_ENQ) state_d = ST_RESP;
				else if (pop_cnt_q != '0) state_d = ST_POP_RD;
				else if (push_cnt_q != '0) state_d = ST_MOVE;
				else state_d = ST_RESP;
			end
			ST_MOVE: begin
				if (move_last) state_d = ST_RESP;
			end
			ST_POP_RD: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (in_xfer) state_d = ST_EXEC;
				else if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		push_we    = 1'b0;
		push_re    = 1'b0;
		push_raddr = push_top;
		pop_we     = 1'b0;
		pop_re     = 1'b0;
		pop_raddr  = pop_top;
		pop_waddr  = push_top - mv_rd_q;
		unique case (state_q)
			ST_EXEC: begin
				if (cmd_q == CMD_ENQ) begin
					push_we = !overflow;
				end else if (pop_cnt_q != '0) begin
					pop_re = 1'b1;
				end else if (push_cnt_q != '0) begin
					push_re = 1'b1;
				end
			end
			ST_MOVE: begin
				pop_we     = 1'b1;
				push_re    = !move_last;
				push_raddr = mv_rd_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_write) cap_q <= cfg_data;
		end
	end

	// stack fill counts and transfer read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_cnt_q <= '0;
			pop_cnt_q  <= '0;
			mv_rd_q    <= '0;
		end else begin
			if (state_q == ST_EXEC) begin
				if (cmd_q == CMD_ENQ) begin
					if (!overflow) push_cnt_q <= push_cnt_q + 1'b1;
				end else if (pop_cnt_q != '0) begin
					pop_cnt_q <= pop_cnt_q - 1'b1;
				end else if (push_cnt_q != '0) begin
					mv_rd_q <= push_top;
				end
			end else if (state_q == ST_MOVE) begin
				if (move_last) begin
					pop_cnt_q  <= push_cnt_q - 1'b1;
					push_cnt_q <= '0;
				end else begin
					mv_rd_q <= mv_rd_q - 1'b1;
				end
			end
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= command;
			val_q <= value;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			res_val_q <= '0;
			if (cmd_q == CMD_ENQ) res_stat_q <= overflow ? STAT_OVERFLOW : STAT_OK;
			else if (pop_cnt_q == '0 && push_cnt_q == '0) res_stat_q <= STAT_UNDERFLOW;
			else res_stat_q <= STAT_OK;
		end else if (state_q == ST_POP_RD) begin
			res_val_q <= pop_rd_ext;
		end else if (state_q == ST_MOVE && move_last) begin
			res_val_q <= push_rd_ext;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q  <= res_val_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_val_q;
	assign status    = out_stat_q;

	// push stack storage
	qts_stack_mem #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_WIDTH)
	) u_push_mem (
		.clk   (clk),
		.we    (push_we),
		.waddr (push_cnt_q[AW-1:0]),
		.wdata (push_wdata),
		.re    (push_re),
		.raddr (push_raddr),
		.rdata (push_rdata)
	);

	// pop stack storage
	qts_stack_mem #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_WIDTH)
	) u_pop_mem (
		.clk   (clk),
		.we    (pop_we),
		.waddr (pop_waddr),
		.wdata (push_rdata),
		.re    (pop_re),
		.raddr (pop_raddr),
		.rdata (pop_rdata)
	);

	// checks
	`QTS_ASSERT_NOW(a_push_cnt_range, 1'b1, push_cnt_q <= CW'(DEPTH))
	`QTS_ASSERT_NOW(a_move_pop_empty, state_q == ST_MOVE, pop_cnt_q == '0 && push_cnt_q != '0)
	`QTS_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_q == ST_EXEC)
	`QTS_ASSERT_NOW(a_status_code, out_valid_q, status != 2'd3)

endmodule
